// ----- rtl/tcr_pkg.sv -----
// tcr_pkg: shared constants, types and the cordic arctangent table for the
// triangle centroid rotator. No dependencies; every other file imports it.
package tcr_pkg;

    // trig precision of cosine and sine
    localparam int TRIG_FRAC_BITS = 14;

    // geometry
    localparam int VTX_W   = 16;
    localparam int NUM_VTX = 3;
    localparam int NUM_CRD = 2 * NUM_VTX;
    localparam int TDATA_W = NUM_CRD * VTX_W;

    // angle register, degrees with 8 fraction bits
    localparam int ANGLE_W = 17;
    localparam int ANG_SW  = ANGLE_W + 1;
    localparam logic [ANGLE_W-1:0]       ANG_FULL_U   = ANGLE_W'(92160);
    localparam logic [ANGLE_W-1:0]       ANG_HALF_U   = ANGLE_W'(46080);
    localparam logic signed [ANG_SW-1:0] ANG_FULL_S   = ANG_SW'(92160);
    localparam logic signed [ANG_SW-1:0] ANG_HALF_S   = ANG_SW'(46080);
    localparam logic signed [ANG_SW-1:0] ANG_QUART_S  = ANG_SW'(23040);
    localparam logic signed [ANG_SW-1:0] ANG_NQUART_S = -ANG_QUART_S;

    // cordic
    localparam int CORDIC_ITERS = 24;
    localparam int ITER_W       = $clog2(CORDIC_ITERS);
    localparam int CORDIC_FRAC  = 30;
    localparam int CORDIC_W     = 32;
    localparam int Z_W          = 31;
    localparam int Z_SHIFT      = 12;
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

    // cosine / sine rounding
    localparam int TRIG_W  = TRIG_FRAC_BITS + 2;
    localparam int TRIG_SH = CORDIC_FRAC - TRIG_FRAC_BITS;
    localparam logic signed [CORDIC_W-1:0] TRIG_RND =
        (TRIG_SH > 0) ? (CORDIC_W'(1) << (TRIG_SH - 1)) : '0;
    localparam logic signed [CORDIC_W-1:0] TRIG_ONE  = CORDIC_W'(1) << TRIG_FRAC_BITS;
    localparam logic signed [CORDIC_W-1:0] TRIG_NONE = -TRIG_ONE;

    // rotation datapath
    localparam int SUM_W   = 18;
    localparam int DIFF_W  = 18;
    localparam int PROD_W  = DIFF_W + TRIG_W;
    localparam int NUM_W   = PROD_W + 2;
    localparam int QUO_W   = NUM_W - TRIG_FRAC_BITS;
    localparam int U_W     = QUO_W + 1;
    localparam int RDIV_SH = U_W + 2;
    localparam int RECIP_W = RDIV_SH - 1;
    localparam int PRODQ_W = U_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP3 =
        RECIP_W'(((64'd1 << RDIV_SH) + 64'd2) / 64'd3);
    localparam logic signed [NUM_W-1:0] ROUND_HALF =
        NUM_W'(3) << (TRIG_FRAC_BITS - 1);
    localparam logic signed [QUO_W-1:0] SAT_MAX = QUO_W'(32767);
    localparam logic signed [QUO_W-1:0] SAT_MIN = -QUO_W'(32768);

    // pipeline
    localparam int ROT_STAGES = 5;
    localparam int PIPE_DEPTH = 1 + CORDIC_ITERS + ROT_STAGES;

    // one triangle: crd[2i] is vertex i x, crd[2i+1] is vertex i y
    typedef struct packed {
        logic                             rotate;
        logic [NUM_CRD-1:0][VTX_W-1:0]    crd;
    } tri_geom_t;

    // payload handed along the cordic cells
    typedef struct packed {
        tri_geom_t                 geom;
        logic                      flip;
        logic [CORDIC_W-1:0]       x;
        logic [CORDIC_W-1:0]       y;
        logic [Z_W-1:0]            z;
    } cell_t;

    // atan(2^-i) in degrees, 20 fraction bits
    function automatic logic signed [Z_W-1:0] atan_q20(input logic [ITER_W-1:0] iter);
        logic signed [Z_W-1:0] v;
        unique case (iter)
            5'd0:    v = Z_W'(47185920);
            5'd1:    v = Z_W'(27855475);
            5'd2:    v = Z_W'(14718068);
            5'd3:    v = Z_W'(7471121);
            5'd4:    v = Z_W'(3750058);
            5'd5:    v = Z_W'(1876857);
            5'd6:    v = Z_W'(938658);
            5'd7:    v = Z_W'(469357);
            5'd8:    v = Z_W'(234682);
            5'd9:    v = Z_W'(117342);
            5'd10:   v = Z_W'(58671);
            5'd11:   v = Z_W'(29335);
            5'd12:   v = Z_W'(14668);
            5'd13:   v = Z_W'(7334);
            5'd14:   v = Z_W'(3667);
            5'd15:   v = Z_W'(1833);
            5'd16:   v = Z_W'(917);
            5'd17:   v = Z_W'(458);
            5'd18:   v = Z_W'(229);
            5'd19:   v = Z_W'(115);
            5'd20:   v = Z_W'(57);
            5'd21:   v = Z_W'(29);
            5'd22:   v = Z_W'(14);
            5'd23:   v = Z_W'(7);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/triangle_centroid_rotator_unit.sv -----
// triangle_centroid_rotator_unit: top level of the triangle rotator.
// Depends on tcr_pkg, tcr_prep, tcr_cordic_cell and tcr_rotate.
//
// rotates each incoming triangle about its centroid by the programmed angle
// and streams out the three new vertices, one triangle per clock. every
// triangle is one transaction on each side; coordinates are signed q7.8 and
// results saturate to 16 bits. with the tuser flag low the vertices come out
// unchanged but still take the full path, so order is always preserved.
// the angle register (degrees, 8 fraction bits, values past 360 wrap) is
// sampled when a triangle is accepted, so rewrite it only while the block is
// empty. each triangle carries its own angle through a row of 24 cordic
// cells, one iteration per cell, so sine and cosine are ready the moment the
// triangle reaches the rotate tail. the path runs through one front
// register, 24 cordic cells and five tail stages (trig rounding, multiply,
// sum, divide by three, saturate). the pipeline holds up to 30 triangles and
// every stage has its own valid bit, so a stalled output only blocks the
// input once all 30 stages are full; with the output side ready, a new
// triangle is accepted every cycle.
module triangle_centroid_rotator_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    // angle register write
    input  logic                          cfg_wr_en,
    input  logic [tcr_pkg::ANGLE_W-1:0]   cfg_wr_data,
    // triangle input
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // vertex0_x, vertex0_y, vertex1_x, vertex1_y, vertex2_x, vertex2_y
    input  logic [tcr_pkg::TDATA_W-1:0]   s_axis_tdata,
    // rotate_enable
    input  logic                          s_axis_tuser,
    // rotated triangle output
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out0_x, out0_y, out1_x, out1_y, out2_x, out2_y
    output logic [tcr_pkg::TDATA_W-1:0]   m_axis_tdata
);
    import tcr_pkg::*;

    logic [ANGLE_W-1:0]  angle_reg;
    tri_geom_t           in_geom;

    // handshake and payload between cells: index 0 is the front register
    logic                chain_valid [CORDIC_ITERS+1];
    logic                chain_ready [CORDIC_ITERS+1];
    cell_t               chain_cell  [CORDIC_ITERS+1];

    logic [NUM_CRD-1:0][VTX_W-1:0] out_crd;

    // angle register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            angle_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            angle_reg <= cfg_wr_data;
        end
    end

    // first field sits in the low bits of tdata
    assign in_geom.crd    = s_axis_tdata;
    assign in_geom.rotate = s_axis_tuser;

    // angle fold and cordic seed
    tcr_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .angle     (angle_reg),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_geom   (in_geom),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_cell  (chain_cell[0])
    );

    // row of cordic cells, cell k does iteration k
    for (genvar k = 0; k < CORDIC_ITERS; k++)
    begin : g_cell
        tcr_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .iter      (ITER_W'(k)),
            .in_valid  (chain_valid[k]),
            .in_ready  (chain_ready[k]),
            .in_cell   (chain_cell[k]),
            .out_valid (chain_valid[k+1]),
            .out_ready (chain_ready[k+1]),
            .out_cell  (chain_cell[k+1])
        );
    end

    // rotation about the centroid, divide by three, saturation
    tcr_rotate u_rotate (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[CORDIC_ITERS]),
        .in_ready  (chain_ready[CORDIC_ITERS]),
        .in_cell   (chain_cell[CORDIC_ITERS]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_crd   (out_crd)
    );

    assign m_axis_tdata = out_crd;

endmodule

// ----- rtl/tcr_prep.sv -----
// tcr_prep: front register of the rotator; folds the angle into +-90 degrees
// and seeds the cordic chain. Depends on tcr_pkg.
module tcr_prep (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcr_pkg::ANGLE_W-1:0]   angle,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tcr_pkg::tri_geom_t            in_geom,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tcr_pkg::cell_t                out_cell
);
    import tcr_pkg::*;

    logic                      valid_reg;
    cell_t                     cell_reg;
    cell_t                     cell_next;
    logic [ANGLE_W-1:0]        a_mod;
    logic signed [ANG_SW-1:0]  a_sgn;
    logic signed [ANG_SW-1:0]  a_fold;
    logic                      flip;

    always_comb
    begin
        // register value is below two full turns, one subtract is enough
        a_mod = (angle >= ANG_FULL_U) ? angle - ANG_FULL_U : angle;
        a_sgn = $signed({1'b0, a_mod});
        if (a_mod >= ANG_HALF_U)
        begin
            a_sgn = $signed({1'b0, a_mod}) - ANG_FULL_S;
        end
        flip   = 1'b0;
        a_fold = a_sgn;
        if (a_sgn > ANG_QUART_S)
        begin
            a_fold = a_sgn - ANG_HALF_S;
            flip   = 1'b1;
        end
        else if (a_sgn < ANG_NQUART_S)
        begin
            a_fold = a_sgn + ANG_HALF_S;
            flip   = 1'b1;
        end
        cell_next.geom = in_geom;
        cell_next.flip = flip;
        cell_next.x    = CORDIC_GAIN;
        cell_next.y    = '0;
        cell_next.z    = {{(Z_W - ANG_SW - Z_SHIFT){a_fold[ANG_SW-1]}}, a_fold,
                          {Z_SHIFT{1'b0}}};
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

// ----- rtl/tcr_cordic_cell.sv -----
// tcr_cordic_cell: one rotation-mode cordic iteration with its own pipeline
// register; the triangle rides along. Depends on tcr_pkg.
module tcr_cordic_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcr_pkg::ITER_W-1:0]    iter,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  tcr_pkg::cell_t                in_cell,
    output logic                          out_valid,
    input  logic                          out_ready,
    output tcr_pkg::cell_t                out_cell
);
    import tcr_pkg::*;

    logic                         valid_reg;
    cell_t                        cell_reg;
    cell_t                        cell_next;
    logic signed [CORDIC_W-1:0]   x_cur;
    logic signed [CORDIC_W-1:0]   y_cur;
    logic signed [CORDIC_W-1:0]   x_sh;
    logic signed [CORDIC_W-1:0]   y_sh;
    logic signed [Z_W-1:0]        z_cur;
    logic signed [Z_W-1:0]        ang;

    always_comb
    begin
        x_cur     = $signed(in_cell.x);
        y_cur     = $signed(in_cell.y);
        z_cur     = $signed(in_cell.z);
        x_sh      = x_cur >>> iter;
        y_sh      = y_cur >>> iter;
        ang       = atan_q20(iter);
        cell_next = in_cell;
        if (!z_cur[Z_W-1])
        begin
            cell_next.x = x_cur - y_sh;
            cell_next.y = y_cur + x_sh;
            cell_next.z = z_cur - ang;
        end
        else
        begin
            cell_next.x = x_cur + y_sh;
            cell_next.y = y_cur - x_sh;
            cell_next.z = z_cur + ang;
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            cell_reg <= cell_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_cell  = cell_reg;

endmodule

// ----- rtl/tcr_rotate.sv -----
// tcr_rotate: five-stage tail that rounds cosine/sine, rotates each vertex
// about the centroid, divides by three and saturates, or passes the vertices through. Depends on tcr_pkg.
module tcr_rotate (
    input  logic                                              clk,
    input  logic                                              rst_n,
    input  logic                                              in_valid,
    output logic                                              in_ready,
    input  tcr_pkg::cell_t                                    in_cell,
    output logic                                              out_valid,
    input  logic                                              out_ready,
    output logic [tcr_pkg::NUM_CRD-1:0][tcr_pkg::VTX_W-1:0]   out_crd
);
    import tcr_pkg::*;

    function automatic logic signed [TRIG_W-1:0] trig_round(
        input logic signed [CORDIC_W-1:0] v
    );
        logic signed [CORDIC_W-1:0] r;
        r = (v + TRIG_RND) >>> TRIG_SH;
        if (r > TRIG_ONE)
        begin
            r = TRIG_ONE;
        end
        else if (r < TRIG_NONE)
        begin
            r = TRIG_NONE;
        end
        return TRIG_W'(r);
    endfunction

    logic [ROT_STAGES-1:0] valid_reg;
    logic [ROT_STAGES-1:0] stage_ready;
    logic [ROT_STAGES-1:0] up_valid;
    logic [ROT_STAGES-1:0] load;

    // stage 1: trig, vertex sum and centroid offsets (times three)
    tri_geom_t                  geom1_reg;
    logic signed [TRIG_W-1:0]   cos1_reg;
    logic signed [TRIG_W-1:0]   sin1_reg;
    logic signed [SUM_W-1:0]    sx1_reg;
    logic signed [SUM_W-1:0]    sy1_reg;
    logic signed [DIFF_W-1:0]   dx1_reg [NUM_VTX];
    logic signed [DIFF_W-1:0]   dy1_reg [NUM_VTX];
    logic signed [CORDIC_W-1:0] cx1;
    logic signed [CORDIC_W-1:0] cy1;
    logic signed [SUM_W-1:0]    sx1_next;
    logic signed [SUM_W-1:0]    sy1_next;
    logic signed [DIFF_W-1:0]   dx1_next [NUM_VTX];
    logic signed [DIFF_W-1:0]   dy1_next [NUM_VTX];

    // stage 2: products
    tri_geom_t                  geom2_reg;
    logic signed [PROD_W-1:0]   pxc2_reg [NUM_VTX];
    logic signed [PROD_W-1:0]   pys2_reg [NUM_VTX];
    logic signed [PROD_W-1:0]   pxs2_reg [NUM_VTX];
    logic signed [PROD_W-1:0]   pyc2_reg [NUM_VTX];
    logic signed [NUM_W-1:0]    bx2_reg;
    logic signed [NUM_W-1:0]    by2_reg;

    // stage 3: numerators
    tri_geom_t                  geom3_reg;
    logic signed [NUM_W-1:0]    num3_reg [NUM_CRD];

    // stage 4: divide by three through the reciprocal
    tri_geom_t                  geom4_reg;
    logic [PRODQ_W-1:0]         prod4_reg [NUM_CRD];
    logic [U_W-1:0]             u4 [NUM_CRD];

    // stage 5: output register
    logic [NUM_CRD-1:0][VTX_W-1:0] crd5_reg;
    logic [NUM_CRD-1:0][VTX_W-1:0] crd5_next;
    logic [QUO_W-1:0]              rq5 [NUM_CRD];
    logic signed [QUO_W-1:0]       r5 [NUM_CRD];

    // handshake along the tail
    always_comb
    begin
        stage_ready[ROT_STAGES-1] = !valid_reg[ROT_STAGES-1] || out_ready;
        for (int k = ROT_STAGES - 2; k >= 0; k--)
        begin
            stage_ready[k] = !valid_reg[k] || stage_ready[k+1];
        end
    end

    assign up_valid = {valid_reg[ROT_STAGES-2:0], in_valid};
    assign load     = stage_ready & up_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < ROT_STAGES; k++)
            begin
                if (stage_ready[k])
                begin
                    valid_reg[k] <= up_valid[k];
                end
            end
        end
    end

    // stage 1 logic
    always_comb
    begin
        cx1 = in_cell.flip ? -$signed(in_cell.x) : $signed(in_cell.x);
        cy1 = in_cell.flip ? -$signed(in_cell.y) : $signed(in_cell.y);
        sx1_next = '0;
        sy1_next = '0;
        for (int i = 0; i < NUM_VTX; i++)
        begin
            sx1_next = sx1_next + SUM_W'($signed(in_cell.geom.crd[2*i]));
            sy1_next = sy1_next + SUM_W'($signed(in_cell.geom.crd[2*i+1]));
        end
        for (int i = 0; i < NUM_VTX; i++)
        begin
            dx1_next[i] = (DIFF_W'($signed(in_cell.geom.crd[2*i])) <<< 1)
                        + DIFF_W'($signed(in_cell.geom.crd[2*i])) - DIFF_W'(sx1_next);
            dy1_next[i] = (DIFF_W'($signed(in_cell.geom.crd[2*i+1])) <<< 1)
                        + DIFF_W'($signed(in_cell.geom.crd[2*i+1])) - DIFF_W'(sy1_next);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
        begin
            geom1_reg <= in_cell.geom;
            cos1_reg  <= trig_round(cx1);
            sin1_reg  <= trig_round(cy1);
            sx1_reg   <= sx1_next;
            sy1_reg   <= sy1_next;
            for (int i = 0; i < NUM_VTX; i++)
            begin
                dx1_reg[i] <= dx1_next[i];
                dy1_reg[i] <= dy1_next[i];
            end
        end
    end

    // stage 2: twelve narrow multiplies, centroid term plus rounding half
    always_ff @(posedge clk)
    begin
        if (load[1])
        begin
            geom2_reg <= geom1_reg;
            bx2_reg   <= (NUM_W'(sx1_reg) <<< TRIG_FRAC_BITS) + ROUND_HALF;
            by2_reg   <= (NUM_W'(sy1_reg) <<< TRIG_FRAC_BITS) + ROUND_HALF;
            for (int i = 0; i < NUM_VTX; i++)
            begin
                pxc2_reg[i] <= dx1_reg[i] * cos1_reg;
                pys2_reg[i] <= dy1_reg[i] * sin1_reg;
                pxs2_reg[i] <= dx1_reg[i] * sin1_reg;
                pyc2_reg[i] <= dy1_reg[i] * cos1_reg;
            end
        end
    end

    // stage 3
    always_ff @(posedge clk)
    begin
        if (load[2])
        begin
            geom3_reg <= geom2_reg;
            for (int i = 0; i < NUM_VTX; i++)
            begin
                num3_reg[2*i]   <= NUM_W'(pxc2_reg[i]) - NUM_W'(pys2_reg[i]) + bx2_reg;
                num3_reg[2*i+1] <= NUM_W'(pxs2_reg[i]) + NUM_W'(pyc2_reg[i]) + by2_reg;
            end
        end
    end

    // stage 4: floor by 2^F is the top bits; biasing by 3*2^(QUO_W-1) makes
    // the quotient non-negative, which is a bit flip plus a set bit
    always_comb
    begin
        for (int j = 0; j < NUM_CRD; j++)
        begin
            u4[j] = {1'b1, ~num3_reg[j][NUM_W-1],
                     num3_reg[j][TRIG_FRAC_BITS +: QUO_W-1]};
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[3])
        begin
            geom4_reg <= geom3_reg;
            for (int j = 0; j < NUM_CRD; j++)
            begin
                prod4_reg[j] <= u4[j] * RECIP3;
            end
        end
    end

    // stage 5: remove bias, saturate, select pass-through
    always_comb
    begin
        for (int j = 0; j < NUM_CRD; j++)
        begin
            rq5[j] = prod4_reg[j][RDIV_SH +: QUO_W];
            r5[j]  = $signed({~rq5[j][QUO_W-1], rq5[j][QUO_W-2:0]});
            if (!geom4_reg.rotate)
            begin
                crd5_next[j] = geom4_reg.crd[j];
            end
            else if (r5[j] > SAT_MAX)
            begin
                crd5_next[j] = VTX_W'(SAT_MAX);
            end
            else if (r5[j] < SAT_MIN)
            begin
                crd5_next[j] = VTX_W'(SAT_MIN);
            end
            else
            begin
                crd5_next[j] = VTX_W'(r5[j]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load[4])
        begin
            crd5_reg <= crd5_next;
        end
    end

    assign in_ready  = stage_ready[0];
    assign out_valid = valid_reg[ROT_STAGES-1];
    assign out_crd   = crd5_reg;

endmodule

// ----- rtl/tcr_checker.sv -----
// tcr_checker: port-level checks of the triangle rotator pipeline, bound to
// the top level. Depends on tcr_pkg and triangle_centroid_rotator_unit.
module tcr_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    input  logic                          s_axis_tready,
    input  logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    input  logic [tcr_pkg::TDATA_W-1:0]   m_axis_tdata
);
    import tcr_pkg::*;

    localparam int OCC_W = $clog2(PIPE_DEPTH + 1) + 1;

    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic             in_xfer;
    logic             out_xfer;

    assign in_xfer  = s_axis_tvalid && s_axis_tready;
    assign out_xfer = m_axis_tvalid && m_axis_tready;

    // transactions inside the pipeline
    always_comb
    begin
        occ_next = occ_reg;
        if (in_xfer && !out_xfer)
        begin
            occ_next = occ_reg + OCC_W'(1);
        end
        else if (!in_xfer && out_xfer)
        begin
            occ_next = occ_reg - OCC_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    // a waiting result holds its data
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output data changed while stalled");

    // no result without a triangle inside
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg == '0 |-> !m_axis_tvalid)
        else $error("result with empty pipeline");

    // never more triangles than stages
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OCC_W'(PIPE_DEPTH))
        else $error("pipeline over capacity");

    // an empty stage anywhere lets the input move
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg < OCC_W'(PIPE_DEPTH) |-> s_axis_tready)
        else $error("input stalled with free stage");

    // a draining output never stalls the input
    a_ready_flow: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output drains");

endmodule

bind triangle_centroid_rotator_unit tcr_checker u_tcr_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- bench/tb.sv -----
// tb: self-checking bench for triangle_centroid_rotator_unit, rotation of
// streamed triangles about their centroid with randomized flow control.
// Depends on tcr_pkg and the rtl top level; a built-in predictor supplies expected vertices.
`timescale 1ns / 100ps

module tb;

    import tcr_pkg::*;

    localparam int     DUT_LATENCY   = 30;
    localparam longint LIMIT_NS      = 64'd12_000_000;
    localparam int     MAX_REPORTS   = 40;

    // angle and cordic constants, degrees with 8 fraction bits
    localparam longint TURN_CODES    = 92160;
    localparam longint HALF_CODES    = 46080;
    localparam longint QUARTER_CODES = 23040;
    localparam longint ANGLE_TO_Z    = 4096;
    localparam longint GAIN_Q30      = 652032874;
    localparam int     ITERATIONS    = 24;
    localparam int     Q30_FRAC      = 30;
    localparam longint TRIG_UNIT     = longint'(1) <<< TRIG_FRAC_BITS;
    localparam longint COORD_MAX     = 32767;
    localparam longint COORD_MIN     = -32768;
    localparam logic [ANGLE_W-1:0] ANGLE_45 = ANGLE_W'(11520);

    localparam longint ATAN_DEG_Q20 [0:23] = '{
        47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
        938658, 469357, 234682, 117342, 58671, 29335,
        14668, 7334, 3667, 1833, 917, 458,
        229, 115, 57, 29, 14, 7
    };

    // quarter-turn boundaries, the last in-range code and codes that wrap past 360
    localparam int WRAP_ANGLES [0:9] = '{
        0, 1, 23040, 23041, 46079, 46080, 69120, 92159, 92160, 131071
    };

    typedef enum int {SINK_OPEN, SINK_LIGHT, SINK_HEAVY, SINK_CADENCE} sink_mode_t;
    typedef logic [NUM_CRD-1:0][VTX_W-1:0] vertex_set_t;

    logic                 clk           = 1'b0;
    logic                 rst_n         = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [ANGLE_W-1:0]   cfg_wr_data   = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [TDATA_W-1:0]   s_axis_tdata  = '0;   // vertex0_x, vertex0_y, ... vertex2_y
    logic                 s_axis_tuser  = 1'b0; // rotate_enable
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TDATA_W-1:0]   m_axis_tdata;         // out0_x, out0_y, ... out2_y

    vertex_set_t expected_triangles[$];
    longint      trig_cos;
    longint      trig_sin;
    int          mismatches        = 0;
    int          triangles_sent    = 0;
    int          triangles_rotated = 0;
    int          triangles_checked = 0;
    int          angle_writes      = 0;
    int          burst_left        = 0;
    int          hold_off_request  = 0;

    triangle_centroid_rotator_unit u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #10 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic longint round_trig(input longint q30);
        localparam int SH = Q30_FRAC - TRIG_FRAC_BITS;
        longint r;
        r = (q30 + (longint'(1) <<< (SH - 1))) >>> SH;
        if (r > TRIG_UNIT)
            r = TRIG_UNIT;
        if (r < -TRIG_UNIT)
            r = -TRIG_UNIT;
        return r;
    endfunction

    // angle reduced to [-90, 90] degrees, cosine and sine negated when a half turn comes off
    function automatic void angle_to_cos_sin(input logic [ANGLE_W-1:0] angle,
                                             output longint c, output longint s);
        longint a;
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        bit     flip;
        flip = 1'b0;
        a = longint'(angle) % TURN_CODES;
        if (a >= HALF_CODES)
            a -= TURN_CODES;
        if (a > QUARTER_CODES)
        begin
            a -= HALF_CODES;
            flip = 1'b1;
        end
        else if (a < -QUARTER_CODES)
        begin
            a += HALF_CODES;
            flip = 1'b1;
        end
        x = GAIN_Q30;
        y = 0;
        z = a * ANGLE_TO_Z;
        for (int i = 0; i < ITERATIONS; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - ATAN_DEG_Q20[i];
            end
            else
            begin
                x = x + ys;
                y = y - xs;
                z = z + ATAN_DEG_Q20[i];
            end
        end
        if (flip)
        begin
            x = -x;
            y = -y;
        end
        c = round_trig(x);
        s = round_trig(y);
    endfunction

    // rounded to nearest, halves upward, then clamped to the coordinate range
    function automatic logic [VTX_W-1:0] scale_and_clamp(input longint num);
        longint den;
        longint q;
        den = 3 * TRIG_UNIT;
        num = num + den / 2;
        q = num / den;
        if ((num % den != 0) && (num < 0))
            q -= 1;
        if (q > COORD_MAX)
            q = COORD_MAX;
        if (q < COORD_MIN)
            q = COORD_MIN;
        return VTX_W'(q);
    endfunction

    function automatic vertex_set_t rotate_about_centroid(input tri_geom_t t);
        vertex_set_t res;
        longint      vx[3];
        longint      vy[3];
        longint      sx;
        longint      sy;
        longint      dx;
        longint      dy;
        if (!t.rotate)
            return t.crd;
        for (int i = 0; i < NUM_VTX; i++)
        begin
            vx[i] = longint'($signed(t.crd[2*i]));
            vy[i] = longint'($signed(t.crd[2*i+1]));
        end
        sx = vx[0] + vx[1] + vx[2];
        sy = vy[0] + vy[1] + vy[2];
        // offsets from the centroid kept exact by scaling everything by three
        for (int i = 0; i < NUM_VTX; i++)
        begin
            dx = 3 * vx[i] - sx;
            dy = 3 * vy[i] - sy;
            res[2*i]   = scale_and_clamp(dx * trig_cos - dy * trig_sin + sx * TRIG_UNIT);
            res[2*i+1] = scale_and_clamp(dx * trig_sin + dy * trig_cos + sy * TRIG_UNIT);
        end
        return res;
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic tri_geom_t random_triangle();
        tri_geom_t t;
        int        kind;
        int        span;
        int        cx;
        int        cy;
        kind = $urandom_range(0, 99);
        if (kind < 45)
        begin
            // realistic triangle: small spread around some center
            span = 1 << $urandom_range(3, 12);
            cx = int'($urandom_range(0, 32000)) - 16000;
            cy = int'($urandom_range(0, 32000)) - 16000;
            for (int i = 0; i < NUM_VTX; i++)
            begin
                t.crd[2*i]   = VTX_W'(cx + int'($urandom_range(0, 2 * span)) - span);
                t.crd[2*i+1] = VTX_W'(cy + int'($urandom_range(0, 2 * span)) - span);
            end
        end
        else if (kind < 75)
        begin
            for (int k = 0; k < NUM_CRD; k++)
                t.crd[k] = VTX_W'($urandom);
        end
        else if (kind < 90)
        begin
            for (int k = 0; k < NUM_CRD; k++)
            begin
                case ($urandom_range(0, 5))
                    0: t.crd[k] = 16'h8000;
                    1: t.crd[k] = 16'h7fff;
                    2: t.crd[k] = 16'hffff;
                    3: t.crd[k] = 16'h0000;
                    4: t.crd[k] = 16'h0001;
                    default: t.crd[k] = VTX_W'($urandom);
                endcase
            end
        end
        else
        begin
            // degenerate: every vertex at one point
            t.crd[0] = VTX_W'($urandom);
            t.crd[1] = VTX_W'($urandom);
            for (int i = 1; i < NUM_VTX; i++)
            begin
                t.crd[2*i]   = t.crd[0];
                t.crd[2*i+1] = t.crd[1];
            end
        end
        t.rotate = ($urandom_range(0, 99) < 80);
        return t;
    endfunction

    function automatic tri_geom_t make_triangle(input logic [VTX_W-1:0] x0, y0, x1, y1,
                                                x2, y2, input logic rot);
        tri_geom_t t;
        t.crd    = {y2, x2, y1, x1, y0, x0};
        t.rotate = rot;
        return t;
    endfunction

    // one transaction on the input side; valid stays high for a following item
    task automatic send_triangle(input tri_geom_t t);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= t.crd;
        s_axis_tuser  <= t.rotate;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_triangles.push_back(rotate_about_centroid(t));
        triangles_sent++;
        if (t.rotate)
            triangles_rotated++;
    endtask

    task automatic pause_input(input int cycles);
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    // bursts of random length, most separated by random gaps, sometimes long stretches
    task automatic send_in_bursts(input tri_geom_t t);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                pause_input($urandom_range(1, 8));
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                     : $urandom_range(1, 30);
        end
        send_triangle(t);
        burst_left--;
    endtask

    task automatic drain_pipeline();
        pause_input(1);
        while (expected_triangles.size() != 0)
            @(posedge clk);
        repeat (DUT_LATENCY)
            @(posedge clk);
        burst_left = 0;
    endtask

    // only called with the pipeline empty
    task automatic write_angle(input logic [ANGLE_W-1:0] value);
        @(negedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
        angle_to_cos_sin(value, trig_cos, trig_sin);
        angle_writes++;
    endtask

    // ---------------------------------------------------------------- result sink

    initial
    begin : result_sink
        sink_mode_t mode;
        int         seg_left;
        int         hold;
        mode     = SINK_OPEN;
        seg_left = 0;
        hold     = 0;
        forever
        begin
            @(negedge clk);
            if (hold_off_request > 0)
            begin
                hold = hold_off_request;
                hold_off_request = 0;
            end
            if (hold > 0)
            begin
                hold--;
                m_axis_tready <= 1'b0;
            end
            else
            begin
                if (seg_left == 0)
                begin
                    mode     = sink_mode_t'($urandom_range(0, 3));
                    seg_left = $urandom_range(10, 150);
                end
                seg_left--;
                case (mode)
                    SINK_OPEN:    m_axis_tready <= 1'b1;
                    SINK_LIGHT:   m_axis_tready <= ($urandom_range(0, 99) >= 25);
                    SINK_HEAVY:   m_axis_tready <= ($urandom_range(0, 99) >= 75);
                    default:      m_axis_tready <= (seg_left % 3 != 0);
                endcase
            end
        end
    end

    // compare every output transaction with the oldest expected triangle
    always @(posedge clk)
    begin : check_results
        vertex_set_t want;
        logic [VTX_W-1:0] got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_triangles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $error("output transaction with no triangle outstanding: %h", m_axis_tdata);
            end
            else
            begin
                want = expected_triangles.pop_front();
                triangles_checked++;
                for (int k = 0; k < NUM_CRD; k++)
                begin
                    got = m_axis_tdata[k*VTX_W +: VTX_W];
                    if (got !== want[k])
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $error("out%0d_%s: expected %0d, actual %0d", k / 2,
                                   (k % 2) ? "y" : "x", $signed(want[k]), $signed(got));
                        else if (mismatches == MAX_REPORTS + 1)
                            $display("further mismatches counted but not listed");
                    end
                end
            end
        end
    end

    // ---------------------------------------------------------------- tests

    // angle register still at its reset value of zero
    task automatic test_reset_angle();
        send_triangle(make_triangle(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                                    16'h0000, 16'h0000, 1'b1));
        send_triangle(make_triangle(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff,
                                    16'h7fff, 16'h7fff, 1'b1));
        send_triangle(make_triangle(16'h8000, 16'h8000, 16'h8000, 16'h8000,
                                    16'h8000, 16'h8000, 1'b0));
        send_triangle(make_triangle(16'h0100, 16'h0000, 16'hff00, 16'h0080,
                                    16'h0000, 16'hff40, 1'b1));
        drain_pipeline();
    endtask

    // field extremes, pass-through and saturation at 45 degrees
    task automatic test_field_extremes();
        write_angle(ANGLE_45);
        send_triangle(make_triangle(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000,
                                    16'h8000, 16'h8000, 1'b1));
        send_triangle(make_triangle(16'h7fff, 16'h7fff, 16'h7fff, 16'h8000,
                                    16'h8000, 16'h8000, 1'b0));
        send_triangle(make_triangle(16'h8000, 16'h7fff, 16'h7fff, 16'h7fff,
                                    16'h8000, 16'h8000, 1'b1));
        send_triangle(make_triangle(16'h5555, 16'haaaa, 16'haaaa, 16'h5555,
                                    16'h5555, 16'h5555, 1'b1));
        send_triangle(make_triangle(16'haaaa, 16'h5555, 16'h5555, 16'haaaa,
                                    16'haaaa, 16'haaaa, 1'b0));
        send_triangle(make_triangle(16'hffff, 16'h0001, 16'h0001, 16'hffff,
                                    16'h0000, 16'h0000, 1'b1));
        send_triangle(make_triangle(16'h7fff, 16'h0000, 16'h8000, 16'h0000,
                                    16'h0000, 16'h7fff, 1'b1));
        drain_pipeline();
    endtask

    // quarter-turn edges, the last code below 360 degrees and codes that wrap
    task automatic test_angle_wrap();
        foreach (WRAP_ANGLES[i])
        begin
            write_angle(ANGLE_W'(WRAP_ANGLES[i]));
            send_triangle(make_triangle(16'h1000, 16'h0200, 16'hf800, 16'h0c00,
                                        16'h0300, 16'hf100, 1'b1));
            drain_pipeline();
        end
    endtask

    task automatic test_random_angles();
        logic [ANGLE_W-1:0] angle;
        for (int phase = 0; phase < 12; phase++)
        begin
            case (phase)
                0:       angle = '0;
                1:       angle = '1;
                2:       angle = ANGLE_W'(TURN_CODES - 1);
                default: angle = ($urandom_range(0, 3) == 0) ? ANGLE_W'($urandom)
                                 : ANGLE_W'($urandom_range(0, TURN_CODES - 1));
            endcase
            write_angle(angle);
            repeat (120)
                send_in_bursts(random_triangle());
            drain_pipeline();
        end
    endtask

    // long output hold-off with the input kept busy, a full drain, then a shorter hold-off under bursty input
    task automatic test_output_backpressure();
        write_angle(ANGLE_W'($urandom_range(0, TURN_CODES - 1)));
        hold_off_request = 300;
        repeat (90)
            send_triangle(random_triangle());
        drain_pipeline();
        hold_off_request = 150;
        repeat (90)
            send_in_bursts(random_triangle());
        drain_pipeline();
    endtask

    // ---------------------------------------------------------------- run control

    initial
    begin : run_tests
        int waited;
        angle_to_cos_sin('0, trig_cos, trig_sin);
        repeat (8)
            @(negedge clk);
        rst_n <= 1'b1;
        repeat (2)
            @(negedge clk);

        test_reset_angle();
        test_field_extremes();
        test_angle_wrap();
        test_random_angles();
        test_output_backpressure();

        pause_input(1);
        waited = 0;
        while (expected_triangles.size() != 0 && waited < 20000)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_triangles.size() != 0)
        begin
            $display("%0d triangles never came out", expected_triangles.size());
            $display("FAIL triangle_centroid_rotator_unit");
            $finish;
        end
        else
        begin
            repeat (DUT_LATENCY + 10)
                @(posedge clk);
            $display("%0d triangles in, %0d rotated, %0d checked, over %0d angle settings",
                     triangles_sent, triangles_rotated, triangles_checked, angle_writes);
            $display("flow control: bursty input, patterned output stalls, long hold-offs");
            if (mismatches == 0)
                $display("PASS triangle_centroid_rotator_unit");
            else
                $display("FAIL triangle_centroid_rotator_unit");
            $finish;
        end
    end

    initial
    begin : watchdog
        #(LIMIT_NS);
        $display("run stopped by the time limit");
        $display("FAIL triangle_centroid_rotator_unit");
        $finish;
    end

endmodule
